### sv/inband_notification_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the in-band notification filter
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INBAND_NOTIFICATION_FILTER_CORE_ASSERT_SVH
`define INBAND_NOTIFICATION_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define IBNF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IBNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IBNF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IBNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/ibnf_pkg.sv
// ----------------------------------------------------------------------------
// ibnf_pkg
// Shared types and constants of the in-band notification filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ibnf_pkg;

    localparam int CNT_W          = 6;   // body count, at most 55
    localparam int HDR_LEN_W      = 4;
    localparam int HDR_W          = 64;
    localparam int LIMIT_W        = 6;
    localparam int MAX_HEADER     = 8;
    localparam int LIMIT_CAP      = 54;
    localparam int DEF_BODY_DEPTH = 64;
    localparam int CFG_IDX_W      = 2;

    localparam logic [HDR_LEN_W-1:0] RST_HDR_LEN = 4'd3;
    localparam logic [LIMIT_W-1:0]   RST_LIMIT   = 6'd48;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_LEN = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_BODY,
        ST_CUR
    } seq_state_t;

    // Effective configuration, already clamped to the legal ranges.
    typedef struct packed {
        logic [HDR_LEN_W-1:0] hdr_len;
        logic [HDR_W-1:0]     header;
        logic [LIMIT_W-1:0]   limit;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       kind;
        logic       last;
    } emit_t;

    function automatic logic [7:0] hdr_char(input logic [HDR_W-1:0] h, input logic [2:0] i);
        return h[{i, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

### sv/ibnf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ibnf_cfg_regs
// Configuration registers with clamping of header length and body limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ibnf_cfg_regs #(
    parameter int BODY_DEPTH = ibnf_pkg::DEF_BODY_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [ibnf_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [ibnf_pkg::HDR_W-1:0]     wr_data,
    output ibnf_pkg::cfg_t                      cfg
);

    localparam int LIM_CAP = (ibnf_pkg::LIMIT_CAP < BODY_DEPTH - 1) ?
                             ibnf_pkg::LIMIT_CAP : BODY_DEPTH - 1;

    logic [ibnf_pkg::HDR_LEN_W-1:0] hdr_len_reg;
    logic [ibnf_pkg::HDR_W-1:0]     header_reg;
    logic [ibnf_pkg::LIMIT_W-1:0]   limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_len_reg <= ibnf_pkg::RST_HDR_LEN;
            header_reg  <= '0;
            limit_reg   <= ibnf_pkg::RST_LIMIT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ibnf_pkg::REG_HEADER_LEN:
                    hdr_len_reg <= wr_data[ibnf_pkg::HDR_LEN_W-1:0];
                ibnf_pkg::REG_HEADER_BYTES:
                    header_reg <= wr_data;
                ibnf_pkg::REG_MAX_BODY_LEN:
                    limit_reg <= wr_data[ibnf_pkg::LIMIT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        cfg.header  = header_reg;
        cfg.hdr_len = (hdr_len_reg > ibnf_pkg::HDR_LEN_W'(ibnf_pkg::MAX_HEADER)) ?
                      ibnf_pkg::HDR_LEN_W'(ibnf_pkg::MAX_HEADER) : hdr_len_reg;
        cfg.limit   = (limit_reg > ibnf_pkg::LIMIT_W'(LIM_CAP)) ?
                      ibnf_pkg::LIMIT_W'(LIM_CAP) : limit_reg;
    end

endmodule

`default_nettype wire

### sv/ibnf_body_ram.sv
// ----------------------------------------------------------------------------
// ibnf_body_ram
// Body byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ibnf_body_ram #(
    parameter int DEPTH = ibnf_pkg::DEF_BODY_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/ibnf_seq.sv
// ----------------------------------------------------------------------------
// ibnf_seq
// Header and CR LF matcher with the release sequencer for held bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ibnf_seq #(
    parameter int AW = 6
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  ibnf_pkg::cfg_t      cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     in_byte,
    input  wire logic           out_free,
    output ibnf_pkg::emit_t     emit,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [AW-1:0]       rd_addr,
    input  wire logic [7:0]     rd_data
);

    localparam int CW = ibnf_pkg::CNT_W;
    localparam int HW = ibnf_pkg::HDR_LEN_W;

    ibnf_pkg::seq_state_t state_reg, state_next;

    logic [HW-1:0] hm_reg, hm_next;
    logic          tm_reg, tm_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [HW-1:0] hdr_n_reg, hdr_n_next;
    logic [CW-1:0] body_n_reg, body_n_next;
    logic          with_cur_reg, with_cur_next;
    logic          kind_reg, kind_next;
    logic [7:0]    cur_reg, cur_next;
    logic          release_now;
    logic          hdr_done;
    logic          body_done;

    function automatic ibnf_pkg::seq_state_t first_stage(input logic [HW-1:0] hn,
                                                         input logic [CW-1:0] bn,
                                                         input logic       wc);
        ibnf_pkg::seq_state_t s;
        if (hn != '0)
            s = ibnf_pkg::ST_HDR;
        else if (bn != '0)
            s = ibnf_pkg::ST_BODY;
        else if (wc)
            s = ibnf_pkg::ST_CUR;
        else
            s = ibnf_pkg::ST_IDLE;
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ibnf_pkg::ST_IDLE;
            hm_reg       <= '0;
            tm_reg       <= 1'b0;
            bc_reg       <= '0;
            idx_reg      <= '0;
            hdr_n_reg    <= '0;
            body_n_reg   <= '0;
            with_cur_reg <= 1'b0;
            kind_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hm_reg       <= hm_next;
            tm_reg       <= tm_next;
            bc_reg       <= bc_next;
            idx_reg      <= idx_next;
            hdr_n_reg    <= hdr_n_next;
            body_n_reg   <= body_n_next;
            with_cur_reg <= with_cur_next;
            kind_reg     <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign hdr_done  = (idx_reg == CW'(hdr_n_reg) - CW'(1));
    assign body_done = (idx_reg == body_n_reg - CW'(1));

    always_comb
    begin
        state_next    = state_reg;
        hm_next       = hm_reg;
        tm_next       = tm_reg;
        bc_next       = bc_reg;
        idx_next      = idx_reg;
        hdr_n_next    = hdr_n_reg;
        body_n_next   = body_n_reg;
        with_cur_next = with_cur_reg;
        kind_next     = kind_reg;
        cur_next      = cur_reg;
        release_now   = 1'b0;
        in_ready      = 1'b0;
        wr_en         = 1'b0;
        emit.valid    = 1'b0;
        emit.data     = cur_reg;
        emit.kind     = kind_reg;
        emit.last     = 1'b0;

        case (state_reg)
            ibnf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                idx_next = '0;
                if (in_valid)
                begin
                    cur_next = in_byte;
                    if (hm_reg < cfg.hdr_len)
                    begin
                        if (in_byte == ibnf_pkg::hdr_char(cfg.header, hm_reg[2:0]))
                        begin
                            hm_next = hm_reg + HW'(1);
                        end
                        else
                        begin
                            // Partial header broken: give back what was held.
                            release_now   = 1'b1;
                            hdr_n_next    = hm_reg;
                            body_n_next   = '0;
                            with_cur_next = 1'b1;
                            kind_next     = 1'b0;
                            hm_next       = '0;
                        end
                    end
                    else if (bc_reg <= cfg.limit)
                    begin
                        wr_en   = 1'b1;
                        bc_next = bc_reg + CW'(1);
                        if (tm_reg && in_byte == ibnf_pkg::CHAR_LF)
                        begin
                            // Notification complete; CR and LF are not released.
                            release_now   = 1'b1;
                            hdr_n_next    = cfg.hdr_len;
                            body_n_next   = bc_reg - CW'(1);
                            with_cur_next = 1'b0;
                            kind_next     = 1'b1;
                            hm_next       = '0;
                            tm_next       = 1'b0;
                            bc_next       = '0;
                        end
                        else if (!tm_reg && in_byte == ibnf_pkg::CHAR_CR)
                        begin
                            tm_next = 1'b1;
                        end
                        else
                        begin
                            tm_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // Body too long: everything goes back out as data.
                        release_now   = 1'b1;
                        hdr_n_next    = cfg.hdr_len;
                        body_n_next   = bc_reg;
                        with_cur_next = 1'b1;
                        kind_next     = 1'b0;
                        hm_next       = '0;
                        tm_next       = 1'b0;
                        bc_next       = '0;
                    end
                    if (release_now)
                    begin
                        state_next = first_stage(hdr_n_next, body_n_next, with_cur_next);
                    end
                end
            end

            ibnf_pkg::ST_HDR:
            begin
                emit.valid = 1'b1;
                emit.data  = ibnf_pkg::hdr_char(cfg.header, idx_reg[2:0]);
                emit.last  = hdr_done && (body_n_reg == '0) && !with_cur_reg;
                if (out_free)
                begin
                    if (hdr_done)
                    begin
                        idx_next = '0;
                        if (body_n_reg != '0)
                            state_next = ibnf_pkg::ST_BODY;
                        else if (with_cur_reg)
                            state_next = ibnf_pkg::ST_CUR;
                        else
                            state_next = ibnf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end

            ibnf_pkg::ST_BODY:
            begin
                emit.valid = 1'b1;
                emit.data  = rd_data;
                emit.last  = body_done && !with_cur_reg;
                if (out_free)
                begin
                    if (body_done)
                    begin
                        idx_next   = '0;
                        state_next = with_cur_reg ? ibnf_pkg::ST_CUR : ibnf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end

            ibnf_pkg::ST_CUR:
            begin
                emit.valid = 1'b1;
                emit.data  = cur_reg;
                emit.last  = 1'b1;
                if (out_free)
                begin
                    state_next = ibnf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ibnf_pkg::ST_IDLE;
            end
        endcase
    end

    // The read address runs one step ahead so that the registered read data
    // always belongs to idx_reg. A store write never targets an entry that is
    // read out in the following cycle, so no forwarding is needed.
    assign wr_addr = AW'(bc_reg);
    assign rd_addr = AW'(idx_next);

endmodule

`default_nettype wire

### sv/inband_notification_filter_core.sv
// ----------------------------------------------------------------------------
// inband_notification_filter_core
// Removes in-band notifications from a received modem byte stream.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_axis channel, one per transfer. Filtered data
// and completed notification text leave on the m_axis channel; tuser is 0 for
// data and 1 for notification text, and tlast marks the final result caused
// by one input byte. Many input bytes cause no result at all.
// The cfg channel writes the header length (index 0), the header characters
// (index 1) and the body limit (index 2); it is always ready, and the user must
// write it only while the block is idle; the block itself does not enforce this.
// An input byte that causes results keeps s_axis_tready low while the release
// sequencer sends them, one per cycle while m_axis does not stall, the body part
// read from the store at an address that is fetched ahead; the first result
// passes through the sequencer state register and then the output register.
// At most 64 results follow one byte.
// A stall on m_axis holds the output register and the sequencer in place.
// Reset returns the registers to their defaults and clears the matcher; the
// body store is not cleared, as only entries of the current notification
// are read back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "inband_notification_filter_core_assert.svh"

module inband_notification_filter_core #(
    parameter int BODY_DEPTH = ibnf_pkg::DEF_BODY_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
    // Output stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
    output logic                                m_axis_tuser,   // [0] kind
    output logic                                m_axis_tlast,
    // Configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ibnf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ibnf_pkg::HDR_W-1:0]     cfg_data
);

    localparam int AW = $clog2(BODY_DEPTH);

    ibnf_pkg::cfg_t  cfg;
    ibnf_pkg::emit_t emit;

    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_kind_reg;
    logic          out_last_reg;

    assign cfg_ready = 1'b1;

    ibnf_cfg_regs #(
        .BODY_DEPTH (BODY_DEPTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ibnf_body_ram #(
        .DEPTH (BODY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ibnf_seq #(
        .AW (AW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .out_free (out_free),
        .emit     (emit),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Output register: loads whenever it is empty or its transfer completes.
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign out_valid_next = out_free ? emit.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_byte_reg <= emit.data;
            out_kind_reg <= emit.kind;
            out_last_reg <= emit.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // A new byte is only taken once every result of the previous one is out
    // of the sequencer.
    `IBNF_ASSERT_IMP(a_accept_after_burst, clk, rst_n,
        s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tlast)

    // Results of one byte follow back to back and share one kind.
    `IBNF_ASSERT_NEXT(a_burst_steady, clk, rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser)))

    // The store is written only in the cycle a byte is taken.
    `IBNF_ASSERT_IMP(a_store_write_on_accept, clk, rst_n,
        wr_en, s_axis_tvalid && s_axis_tready)

endmodule

`default_nettype wire
